@@ rtl/core/cdq_pkg.sv @@
// ----------------------------------------------------------------------------
// cdq_pkg
// Shared constants, operation codes and cell control type for the deque.
// ----------------------------------------------------------------------------
package cdq_pkg;

	localparam int MAX_DEPTH_DEF = 64;
	localparam int DATA_BITS_DEF = 32;

	localparam int KIND_W = 3;
	localparam int CAP_W  = 7;
	localparam int CAP_RESET = 64;

	localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
	localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd1;
	localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
	localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd3;
	localparam logic [KIND_W-1:0] KIND_NOP        = 3'd4;

	// broadcast to every cell of the chain, at most one push or pop bit high; clear may join it
	typedef struct packed {
		logic clear;
		logic push_front;
		logic push_back;
		logic pop_front;
		logic pop_back;
	} cell_ctl_t;

endpackage

@@ rtl/core/cdq_if.sv @@
// ----------------------------------------------------------------------------
// cdq_if
// Valid/ready channels for deque operations and deque results.
// ----------------------------------------------------------------------------
interface cdq_op_if #(
	parameter int DATA_BITS = cdq_pkg::DATA_BITS_DEF
);
	logic                        valid;
	logic                        ready;
	logic [cdq_pkg::KIND_W-1:0]  kind;
	logic signed [DATA_BITS-1:0] value;

	modport source (output valid, kind, value, input ready);
	modport sink (input valid, kind, value, output ready);
endinterface

interface cdq_res_if #(
	parameter int DATA_BITS = cdq_pkg::DATA_BITS_DEF
);
	logic                        valid;
	logic                        ready;
	logic                        accepted;
	logic signed [DATA_BITS-1:0] front_value;
	logic signed [DATA_BITS-1:0] rear_value;
	logic                        empty_res;
	logic                        full_res;
	logic [cdq_pkg::CAP_W-1:0]   occupancy;

	modport source (output valid, accepted, front_value, rear_value, empty_res, full_res,
		occupancy, input ready);
	modport sink (input valid, accepted, front_value, rear_value, empty_res, full_res,
		occupancy, output ready);
endinterface

@@ rtl/core/circular_deque.sv @@
// ----------------------------------------------------------------------------
// circular_deque
// Double-ended queue held in a row of shifting cells, front at cell zero.
// ----------------------------------------------------------------------------
//  channel  dir  handshake         payload
//  op       in   valid/ready       kind, value
//  res      out  valid/ready       accepted, front_value, rear_value,
//                                  empty_res, full_res, occupancy
//  cfg      in   cfg_we            cfg_wdata (capacity)
//
//  one operation per cycle; the cells are updated in the same edge that takes
//  the transfer and the result register is valid from the next cycle.
//  a new operation is taken while the result register is empty or being read.
//  front and rear come straight from the cell row, the rear cell being found
//  by the edge of the occupied thermometer.
//  reset and a capacity write empty the deque at once, no clearing pass.
// ----------------------------------------------------------------------------
module circular_deque #(
	parameter int MAX_DEPTH = cdq_pkg::MAX_DEPTH_DEF,
	parameter int DATA_BITS = cdq_pkg::DATA_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [cdq_pkg::CAP_W-1:0]   cfg_wdata,
	cdq_op_if.sink                      op,
	cdq_res_if.source                   res
);

	localparam int CAP_MAX   = (1 << cdq_pkg::CAP_W) - 1;
	localparam int CAP_LIMIT = (MAX_DEPTH < CAP_MAX) ? MAX_DEPTH : CAP_MAX;
	localparam int CAP_INIT  = (cdq_pkg::CAP_RESET < CAP_LIMIT) ? cdq_pkg::CAP_RESET : CAP_LIMIT;

	logic [cdq_pkg::CAP_W-1:0] cap_q;
	logic [cdq_pkg::CAP_W-1:0] count_q;
	logic [cdq_pkg::CAP_W-1:0] cap_new;
	logic                      valid_q;
	logic                      accepted_q;
	logic                      fire;
	logic                      can_push;
	logic                      can_pop;
	logic                      ok;
	cdq_pkg::cell_ctl_t        ctl;

	logic [DATA_BITS-1:0] cell_data [MAX_DEPTH];
	logic [DATA_BITS-1:0] cell_tap  [MAX_DEPTH];
	logic [MAX_DEPTH-1:0] cell_occ;
	logic [MAX_DEPTH-1:0] cell_rear;
	logic [DATA_BITS-1:0] rear_word;

	assign op.ready = !valid_q || res.ready;
	assign fire     = op.valid && op.ready;
	assign can_push = count_q < cap_q;
	assign can_pop  = count_q != '0;

	always_comb begin
		if (cfg_wdata == '0) begin
			cap_new = cdq_pkg::CAP_W'(1);
		end else if (cfg_wdata > cdq_pkg::CAP_W'(CAP_LIMIT)) begin
			cap_new = cdq_pkg::CAP_W'(CAP_LIMIT);
		end else begin
			cap_new = cfg_wdata;
		end
	end

	always_comb begin
		ctl            = '0;
		ok             = 1'b0;
		ctl.clear      = cfg_we;
		unique case (op.kind)
			cdq_pkg::KIND_PUSH_FRONT: begin
				ok             = can_push;
				ctl.push_front = fire && can_push;
			end
			cdq_pkg::KIND_PUSH_BACK: begin
				ok            = can_push;
				ctl.push_back = fire && can_push;
			end
			cdq_pkg::KIND_POP_FRONT: begin
				ok            = can_pop;
				ctl.pop_front = fire && can_pop;
			end
			cdq_pkg::KIND_POP_BACK: begin
				ok           = can_pop;
				ctl.pop_back = fire && can_pop;
			end
			cdq_pkg::KIND_NOP: begin
				ok = 1'b1;
			end
			default: begin
				ok = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q   <= cdq_pkg::CAP_W'(CAP_INIT);
			count_q <= '0;
			valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_q   <= cap_new;
				count_q <= '0;
			end else if (ctl.push_front || ctl.push_back) begin
				count_q <= count_q + cdq_pkg::CAP_W'(1);
			end else if (ctl.pop_front || ctl.pop_back) begin
				count_q <= count_q - cdq_pkg::CAP_W'(1);
			end
			if (fire) begin
				valid_q <= 1'b1;
			end else if (res.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			accepted_q <= ok;
		end
	end

	for (genvar i = 0; i < MAX_DEPTH; i++) begin : g_cell
		logic [DATA_BITS-1:0] l_data;
		logic                 l_occ;
		logic [DATA_BITS-1:0] r_data;
		logic                 r_occ;

		if (i == 0) begin : g_head
			assign l_data = op.value;
			assign l_occ  = 1'b1;
		end else begin : g_mid_l
			assign l_data = cell_data[i-1];
			assign l_occ  = cell_occ[i-1];
		end

		if (i == MAX_DEPTH - 1) begin : g_tail
			assign r_data = '0;
			assign r_occ  = 1'b0;
		end else begin : g_mid_r
			assign r_data = cell_data[i+1];
			assign r_occ  = cell_occ[i+1];
		end

		cdq_cell #(
			.DATA_BITS (DATA_BITS)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.push_data  (op.value),
			.left_data  (l_data),
			.left_occ   (l_occ),
			.right_data (r_data),
			.right_occ  (r_occ),
			.data       (cell_data[i]),
			.occ        (cell_occ[i]),
			.rear       (cell_rear[i]),
			.rear_tap   (cell_tap[i])
		);
	end

	// at most one cell marks the rear, so an or of the taps selects it
	always_comb begin
		rear_word = '0;
		for (int i = 0; i < MAX_DEPTH; i++) begin
			rear_word = rear_word | cell_tap[i];
		end
	end

	assign res.valid       = valid_q;
	assign res.accepted    = accepted_q;
	assign res.empty_res   = count_q == '0;
	assign res.full_res    = count_q == cap_q;
	assign res.occupancy   = count_q;
	assign res.front_value = cell_occ[0] ? cell_data[0] : '1;
	assign res.rear_value  = cell_occ[0] ? rear_word : '1;

`ifndef SYNTHESIS
	a_count_vs_cells: assert property (@(posedge clk) disable iff (!arst_n)
		cell_occ[0] == (count_q != '0))
		else $error("occupied cells disagree with count");

	a_single_rear: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cell_rear))
		else $error("more than one rear cell");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= cap_q)
		else $error("count above capacity");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.push_front || ctl.push_back) |=> count_q == $past(count_q) + cdq_pkg::CAP_W'(1))
		else $error("push did not grow the deque");
`endif

endmodule

@@ rtl/core/cdq_cell.sv @@
// ----------------------------------------------------------------------------
// cdq_cell
// One storage position of the deque chain: a data word and an occupied flag.
// ----------------------------------------------------------------------------
module cdq_cell #(
	parameter int DATA_BITS = cdq_pkg::DATA_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cdq_pkg::cell_ctl_t     ctl,
	input  logic [DATA_BITS-1:0]   push_data,
	input  logic [DATA_BITS-1:0]   left_data,
	input  logic                   left_occ,
	input  logic [DATA_BITS-1:0]   right_data,
	input  logic                   right_occ,
	output logic [DATA_BITS-1:0]   data,
	output logic                   occ,
	output logic                   rear,
	output logic [DATA_BITS-1:0]   rear_tap
);

	logic [DATA_BITS-1:0] data_q;
	logic                 occ_q;

	// occupied flags form a thermometer from the front end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else if (ctl.clear) begin
			occ_q <= 1'b0;
		end else if (ctl.push_front || ctl.push_back) begin
			occ_q <= left_occ;
		end else if (ctl.pop_front || ctl.pop_back) begin
			occ_q <= right_occ;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.push_front) begin
			data_q <= left_data;
		end else if (ctl.pop_front) begin
			data_q <= right_data;
		end else if (ctl.push_back && !occ_q && left_occ) begin
			// first free position takes the new rear word
			data_q <= push_data;
		end
	end

	assign data     = data_q;
	assign occ      = occ_q;
	assign rear     = occ_q && !right_occ;
	assign rear_tap = rear ? data_q : '0;

endmodule

@@ tb/tb_circular_deque.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_circular_deque
// Self-checking bench for the deque: a queue-based shadow predicts the status
// after each operation transfer, and every result transfer is checked against
// it, over directed corner cases and biased random walks at several capacities.
// ----------------------------------------------------------------------------
module tb_circular_deque;
	import cdq_pkg::*;

	localparam int DEPTH = MAX_DEPTH_DEF;
	localparam int DW = DATA_BITS_DEF;
	localparam int LONG_HOLD = 300;
	localparam logic [KIND_W-1:0] KIND_UNUSED_FIRST = 3'd5;
	localparam logic [KIND_W-1:0] KIND_UNUSED_LAST = 3'd7;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic signed [DW-1:0] value;
	} deque_op_t;

	typedef struct packed {
		logic accepted;
		logic signed [DW-1:0] front_value;
		logic signed [DW-1:0] rear_value;
		logic empty_res;
		logic full_res;
		logic [CAP_W-1:0] occupancy;
	} deque_status_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CAP_W-1:0] cfg_wdata = '0;
	logic drv_valid = 1'b0;
	logic [KIND_W-1:0] drv_kind = KIND_NOP;
	logic signed [DW-1:0] drv_value = '0;
	logic rcv_ready = 1'b0;

	cdq_op_if #(.DATA_BITS(DW)) op_if ();
	cdq_res_if #(.DATA_BITS(DW)) res_if ();

	assign op_if.valid = drv_valid;
	assign op_if.kind = drv_kind;
	assign op_if.value = drv_value;
	assign res_if.ready = rcv_ready;

	circular_deque #(.MAX_DEPTH(DEPTH), .DATA_BITS(DW)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.op(op_if.sink),
		.res(res_if.source)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// shadow of the deque contents and capacity
	logic signed [DW-1:0] deque_shadow[$];
	int unsigned shadow_cap = CAP_RESET;

	deque_op_t op_pending_q[$];
	deque_status_t status_expected_q[$];
	deque_op_t drv_next;
	bit idle_en = 1'b1;
	int send_gap = 0;
	int stall_left = 0;
	int hold_left = 0;
	int long_hold_req = 0;
	int long_hold_done = 0;

	int n_ops_accepted = 0;
	int n_results_checked = 0;
	int n_refused = 0;
	int n_full_seen = 0;
	int n_cap_writes = 0;
	int n_mismatch = 0;

	function automatic deque_status_t predict_status(input logic [KIND_W-1:0] kind,
			input logic signed [DW-1:0] value);
		deque_status_t st;
		st.accepted = 1'b0;
		case (kind)
			KIND_PUSH_FRONT: begin
				if (deque_shadow.size() < shadow_cap) begin
					deque_shadow.push_front(value);
					st.accepted = 1'b1;
				end
			end
			KIND_PUSH_BACK: begin
				if (deque_shadow.size() < shadow_cap) begin
					deque_shadow.push_back(value);
					st.accepted = 1'b1;
				end
			end
			KIND_POP_FRONT: begin
				if (deque_shadow.size() != 0) begin
					void'(deque_shadow.pop_front());
					st.accepted = 1'b1;
				end
			end
			KIND_POP_BACK: begin
				if (deque_shadow.size() != 0) begin
					void'(deque_shadow.pop_back());
					st.accepted = 1'b1;
				end
			end
			KIND_NOP: st.accepted = 1'b1;
			default: st.accepted = 1'b0;
		endcase
		if (!st.accepted)
			n_refused++;
		if (deque_shadow.size() != 0) begin
			st.front_value = deque_shadow[0];
			st.rear_value = deque_shadow[$];
		end else begin
			st.front_value = '1;
			st.rear_value = '1;
		end
		st.empty_res = (deque_shadow.size() == 0);
		st.full_res = (deque_shadow.size() == shadow_cap);
		st.occupancy = CAP_W'(deque_shadow.size());
		if (st.full_res)
			n_full_seen++;
		return st;
	endfunction

	// sender: offers pending operations, with random gaps between them
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drv_valid <= 1'b0;
			drv_kind <= KIND_NOP;
			drv_value <= '0;
			send_gap = 0;
		end else begin
			if (drv_valid && op_if.ready) begin
				status_expected_q.push_back(predict_status(drv_kind, drv_value));
				n_ops_accepted++;
			end
			if (!drv_valid || op_if.ready) begin
				if (send_gap > 0) begin
					send_gap--;
					drv_valid <= 1'b0;
				end else if (op_pending_q.size() != 0) begin
					drv_next = op_pending_q.pop_front();
					drv_valid <= 1'b1;
					drv_kind <= drv_next.kind;
					drv_value <= drv_next.value;
					if (idle_en && $urandom_range(0, 5) == 0)
						send_gap = $urandom_range(1, 12);
				end else begin
					drv_valid <= 1'b0;
				end
			end
		end
	end

	// receiver ready: long hold on request, otherwise random stall bursts
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rcv_ready <= 1'b0;
			stall_left = 0;
			hold_left = 0;
		end else begin
			if (long_hold_done < long_hold_req) begin
				long_hold_done++;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				rcv_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				rcv_ready <= 1'b0;
			end else if (idle_en && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 12) - 1;
				rcv_ready <= 1'b0;
			end else begin
				rcv_ready <= 1'b1;
			end
		end
	end

	// result checker
	always @(posedge clk) begin : check_results
		deque_status_t want;
		deque_status_t got;
		if (arst_n && res_if.valid && rcv_ready) begin
			got.accepted = res_if.accepted;
			got.front_value = res_if.front_value;
			got.rear_value = res_if.rear_value;
			got.empty_res = res_if.empty_res;
			got.full_res = res_if.full_res;
			got.occupancy = res_if.occupancy;
			if (status_expected_q.size() == 0) begin
				n_mismatch++;
				if (n_mismatch <= 10)
					$display("%0t: result transfer with nothing expected", $realtime);
			end else begin
				want = status_expected_q.pop_front();
				n_results_checked++;
				if (got !== want) begin
					n_mismatch++;
					if (n_mismatch <= 10) begin
						$display("%0t: mismatch exp acc=%b front=%0d rear=%0d empty=%b full=%b occ=%0d",
							$realtime, want.accepted, want.front_value, want.rear_value,
							want.empty_res, want.full_res, want.occupancy);
						$display("%0t:          got acc=%b front=%0d rear=%0d empty=%b full=%b occ=%0d",
							$realtime, got.accepted, got.front_value, got.rear_value,
							got.empty_res, got.full_res, got.occupancy);
					end
				end
			end
		end
	end

	task automatic wait_idle();
		@(negedge clk);
		while (op_pending_q.size() != 0 || drv_valid || status_expected_q.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_capacity(input logic [CAP_W-1:0] cap);
		wait_idle();
		repeat (2) @(negedge clk);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= cap;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (cap == 0)
			shadow_cap = 1;
		else if (cap > DEPTH)
			shadow_cap = DEPTH;
		else
			shadow_cap = cap;
		deque_shadow.delete();
		n_cap_writes++;
		@(negedge clk);
	endtask

	task automatic add_op(input logic [KIND_W-1:0] kind, input logic signed [DW-1:0] value);
		deque_op_t o;
		o.kind = kind;
		o.value = value;
		op_pending_q.push_back(o);
	endtask

	// random walk over the fill level: segments lean to pushes or pops so that
	// both full and empty are reached at any capacity
	task automatic add_random_ops(input int count);
		int push_pct;
		int seg_left;
		int r;
		logic [KIND_W-1:0] kind;
		logic signed [DW-1:0] value;
		push_pct = 50;
		seg_left = 0;
		for (int i = 0; i < count; i++) begin
			if (seg_left == 0) begin
				case ($urandom_range(0, 2))
					0: push_pct = 85;
					1: push_pct = 15;
					default: push_pct = 50;
				endcase
				seg_left = $urandom_range(10, 2 * shadow_cap + 10);
			end
			seg_left--;
			r = $urandom_range(0, 99);
			if (r < 3)
				kind = KIND_W'($urandom_range(KIND_UNUSED_FIRST, KIND_UNUSED_LAST));
			else if (r < 8)
				kind = KIND_NOP;
			else if ($urandom_range(0, 99) < push_pct)
				kind = $urandom_range(0, 1) ? KIND_PUSH_FRONT : KIND_PUSH_BACK;
			else
				kind = $urandom_range(0, 1) ? KIND_POP_FRONT : KIND_POP_BACK;
			case ($urandom_range(0, 15))
				0: value = '0;
				1: value = '1;
				2: value = 32'sh7fffffff;
				3: value = 32'sh80000000;
				default: value = $urandom;
			endcase
			add_op(kind, value);
		end
	endtask

	initial begin : stimulus
		logic [CAP_W-1:0] cap_plan[10];
		cap_plan = '{7'd64, 7'd1, 7'd2, 7'd127, 7'd3, 7'd0, 7'd5, 7'd16, 7'd64, 7'd64};
		cap_plan[6] = CAP_W'($urandom_range(4, 63));
		cap_plan[7] = CAP_W'($urandom_range(65, 127));

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty deque corners, unused kinds, extreme values at both ends
		add_op(KIND_POP_FRONT, 32'sd7);
		add_op(KIND_POP_BACK, 32'sd7);
		add_op(KIND_NOP, 32'sd0);
		add_op(KIND_UNUSED_FIRST, 32'sd1);
		add_op(KIND_UNUSED_FIRST + 3'd1, 32'sd2);
		add_op(KIND_UNUSED_LAST, 32'sd3);
		add_op(KIND_PUSH_FRONT, 32'sh7fffffff);
		add_op(KIND_PUSH_BACK, 32'sh80000000);
		add_op(KIND_PUSH_FRONT, -32'sd1);
		add_op(KIND_PUSH_BACK, 32'sd0);
		add_op(KIND_POP_FRONT, 32'sd0);
		add_op(KIND_POP_BACK, 32'sd0);
		add_op(KIND_POP_FRONT, 32'sd0);
		add_op(KIND_POP_BACK, 32'sd0);
		add_op(KIND_POP_FRONT, 32'sd0);

		// single-entry deque: refused push when full, refused pop when empty
		write_capacity(7'd1);
		add_op(KIND_PUSH_BACK, 32'sh5a5a5a5a);
		add_op(KIND_PUSH_FRONT, 32'sd1);
		add_op(KIND_POP_FRONT, 32'sd0);
		add_op(KIND_POP_BACK, 32'sd0);
		add_op(KIND_PUSH_FRONT, 32'sh12345678);

		// zero is taken as one
		write_capacity(7'd0);
		add_op(KIND_PUSH_FRONT, -32'sd2);
		add_op(KIND_PUSH_BACK, 32'sd9);

		for (int p = 0; p < 10; p++) begin
			write_capacity(cap_plan[p]);
			idle_en = !(p == 3 || p == 7 || p == 9);
			// last phase: receiver holds off while the sender keeps offering
			if (p == 9)
				long_hold_req++;
			add_random_ops(195);
		end

		wait_idle();
		repeat (4) @(posedge clk);
		$display("covered %0d operations (%0d refused, %0d at full) over %0d capacity writes",
			n_ops_accepted, n_refused, n_full_seen, n_cap_writes);
		$display("checked %0d results, %0d mismatches", n_results_checked, n_mismatch);
		if (n_mismatch == 0 && status_expected_q.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin : watchdog
		#(5_000_000);
		$display("timeout: %0d results still expected", status_expected_q.size());
		$display("Some tests failed");
		$finish;
	end

endmodule
